// ----- rtl/pltr_pkg.sv -----
package pltr_pkg;

    // Table size and derived index width.
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Fixed field widths.
    localparam int OP_W   = 3;
    localparam int ID_W   = 31;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 6;
    localparam int STAT_W = 3;

    // Width of one table word: tag above start time.
    localparam int WORD_W = ID_W + TIME_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Command codes.
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_TRACK_AUTO = 3'd1,
        OP_TRACK_ID   = 3'd2,
        OP_FINISH     = 3'd3,
        OP_FLUSH      = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STS_TRACKED   = 3'd0,
        STS_DROPPED   = 3'd1,
        STS_FINISHED  = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_FLUSH     = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_TRACK,
        SEQ_FIND,
        SEQ_FLUSH
    } seq_state_t;

    // Per-cycle action the sequencer asks of the datapath.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_TRACK,
        ACT_DROP,
        ACT_FINISH,
        ACT_MISS,
        ACT_FLUSH
    } act_t;

    // Input transfer payload.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] packet_id;
    } cmd_t;

    // Result transfer payload.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   result_id;
        logic [SLOT_W-1:0] slot;
        logic              entry_valid;
        logic [TIME_W-1:0] latency;
        logic              last;
    } rsp_t;

    // Sequencer to datapath.
    typedef struct packed {
        act_t             act;
        logic [IDX_W-1:0] scan_idx;
        logic [IDX_W-1:0] cmp_idx;
    } seq_ctl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic scan_free;
        logic cmp_hit;
    } seq_stat_t;

endpackage

// ----- rtl/pltr_ram.sv -----
module pltr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port: write and registered read at one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/pltr_alu.sv -----
module pltr_alu
    import pltr_pkg::*;
(
    input  logic [ID_W-1:0]   tag,
    input  logic [ID_W-1:0]   key,
    input  logic [TIME_W-1:0] now,
    input  logic [TIME_W-1:0] start_time,
    output logic              match,
    output logic [TIME_W-1:0] elapsed
);

    // Shared compare and modular subtract, used once per scanned slot.
    always_comb
    begin
        match   = (tag == key);
        elapsed = now - start_time;
    end

endmodule

// ----- rtl/pltr_seq.sv -----
module pltr_seq
    import pltr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] op,
    input  seq_stat_t       stat,
    output seq_ctl_t        ctl,
    output logic            busy
);

    seq_state_t       state_reg,    state_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg,  cmp_idx_next;
    logic             cmp_vld_reg,  cmp_vld_next;
    logic             accept;

    assign accept = start && (state_reg == SEQ_IDLE);

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SEQ_IDLE;
            scan_idx_reg <= '0;
            cmp_idx_reg  <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_idx_reg  <= cmp_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
        end
    end

    // Next state. Find and flush run a two-stage scan: the table is read at
    // the scan index and the word comes back in the next cycle at the compare
    // index.
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        cmp_vld_next  = cmp_vld_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                scan_idx_next = '0;
                cmp_vld_next  = 1'b0;
                if (accept)
                begin
                    case (op)
                        OP_TRACK_AUTO, OP_TRACK_ID: state_next = SEQ_TRACK;
                        OP_FINISH:                  state_next = SEQ_FIND;
                        OP_FLUSH:                   state_next = SEQ_FLUSH;
                        default:                    state_next = SEQ_IDLE;
                    endcase
                end
            end
            SEQ_TRACK:
            begin
                if (stat.scan_free || (scan_idx_reg == LAST_IDX))
                begin
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            SEQ_FIND, SEQ_FLUSH:
            begin
                if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX ||
                                    (state_reg == SEQ_FIND && stat.cmp_hit)))
                begin
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx_reg;
                    if (scan_idx_reg != LAST_IDX)
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Outputs: the action for the datapath in this cycle.
    always_comb
    begin
        ctl.act      = ACT_NONE;
        ctl.scan_idx = scan_idx_reg;
        ctl.cmp_idx  = cmp_idx_reg;
        busy         = (state_reg != SEQ_IDLE);
        case (state_reg)
            SEQ_TRACK:
            begin
                if (stat.scan_free)
                begin
                    ctl.act = ACT_TRACK;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    ctl.act = ACT_DROP;
                end
            end
            SEQ_FIND:
            begin
                if (cmp_vld_reg && stat.cmp_hit)
                begin
                    ctl.act = ACT_FINISH;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    ctl.act = ACT_MISS;
                end
            end
            SEQ_FLUSH:
            begin
                if (cmp_vld_reg)
                begin
                    ctl.act = ACT_FLUSH;
                end
            end
            default:
            begin
                ctl.act = ACT_NONE;
            end
        endcase
    end

endmodule

// ----- rtl/packet_latency_tracker_unit.sv -----
// Channel   Handshake          Payload   Notes
// command   start / busy       cmd       transfer when start high, busy low
// result    done (strobe)      result    one cycle per result, never held
//
// Tick only advances the clock and gives no result. Track scans the busy flags
// one slot per cycle; each result is registered and shows in the cycle after
// its action. Finish and flush walk the table through its registered read
// port, one slot per cycle once the first word is read; flush gives one result
// per cycle, one per slot. busy falls in the cycle the last result shows.
// Reset clears the busy flags, counter and clock at once; no clearing pass.
// The receiver cannot stall: each result is on the ports for one cycle only.
module packet_latency_tracker_unit
    import pltr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output rsp_t result,
    output logic done
);

    seq_ctl_t          ctl;
    seq_stat_t         stat;
    logic              accept;
    logic [ENTRIES-1:0] slot_busy_reg, slot_busy_next;
    logic [ID_W-1:0]   auto_id_reg,   auto_id_next;
    logic [TIME_W-1:0] time_reg,      time_next;
    logic [ID_W-1:0]   id_reg,        id_next;
    rsp_t              rsp_reg,       rsp_next;
    logic              done_reg,      done_next;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [ID_W-1:0]   rd_tag;
    logic [TIME_W-1:0] rd_time;
    logic              match;
    logic [TIME_W-1:0] elapsed;
    logic              cmp_busy;

    assign accept = start && !busy;

    pltr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (cmd.op),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // Tag and start time of each slot.
    assign ram_wdata = {id_reg, time_reg};

    pltr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.act == ACT_TRACK),
        .addr  (ctl.scan_idx),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_tag  = ram_rdata[WORD_W-1:TIME_W];
    assign rd_time = ram_rdata[TIME_W-1:0];

    pltr_alu u_alu (
        .tag        (rd_tag),
        .key        (id_reg),
        .now        (time_reg),
        .start_time (rd_time),
        .match      (match),
        .elapsed    (elapsed)
    );

    // Status back to the sequencer.
    assign cmp_busy       = slot_busy_reg[ctl.cmp_idx];
    assign stat.scan_free = !slot_busy_reg[ctl.scan_idx];
    assign stat.cmp_hit   = cmp_busy && match;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_busy_reg <= '0;
            auto_id_reg   <= '0;
            time_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            slot_busy_reg <= slot_busy_next;
            auto_id_reg   <= auto_id_next;
            time_reg      <= time_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        rsp_reg <= rsp_next;
    end

    // Command capture: clock tick, auto id and the id in play.
    always_comb
    begin
        auto_id_next = auto_id_reg;
        time_next    = time_reg;
        id_next      = id_reg;
        if (accept)
        begin
            case (cmd.op)
                OP_TICK:
                begin
                    time_next = time_reg + TIME_W'(1);
                end
                OP_TRACK_AUTO:
                begin
                    id_next      = auto_id_reg;
                    auto_id_next = auto_id_reg + ID_W'(1);
                end
                default:
                begin
                    id_next = cmd.packet_id;
                end
            endcase
        end
    end

    // Busy flags and the result for this cycle's action.
    always_comb
    begin
        slot_busy_next       = slot_busy_reg;
        done_next            = (ctl.act != ACT_NONE);
        rsp_next.status      = STS_TRACKED;
        rsp_next.result_id   = id_reg;
        rsp_next.slot        = '0;
        rsp_next.entry_valid = 1'b0;
        rsp_next.latency     = '0;
        rsp_next.last        = 1'b1;
        case (ctl.act)
            ACT_TRACK:
            begin
                slot_busy_next[ctl.scan_idx] = 1'b1;
                rsp_next.slot                = SLOT_W'(ctl.scan_idx);
            end
            ACT_DROP:
            begin
                rsp_next.status = STS_DROPPED;
            end
            ACT_FINISH:
            begin
                slot_busy_next[ctl.cmp_idx] = 1'b0;
                rsp_next.status             = STS_FINISHED;
                rsp_next.slot               = SLOT_W'(ctl.cmp_idx);
                rsp_next.latency            = elapsed;
            end
            ACT_MISS:
            begin
                rsp_next.status = STS_NOT_FOUND;
            end
            ACT_FLUSH:
            begin
                slot_busy_next[ctl.cmp_idx] = 1'b0;
                rsp_next.status             = STS_FLUSH;
                rsp_next.result_id          = cmp_busy ? rd_tag : '0;
                rsp_next.slot               = SLOT_W'(ctl.cmp_idx);
                rsp_next.entry_valid        = cmp_busy;
                rsp_next.last               = (ctl.cmp_idx == LAST_IDX);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign result = rsp_reg;
    assign done   = done_reg;

endmodule

// ----- rtl/pltr_checker.sv -----
module pltr_checker
    import pltr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input rsp_t result,
    input logic done
);

    // A result only follows a cycle in which the block was working.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result strobe without preceding busy cycle");

    // A tick transfer never makes the block busy.
    a_tick_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op == OP_TICK) |=> !busy)
    else $error("tick transfer left the block busy");

    // Track and finish give a single result, so it is always the last.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STS_FLUSH) |-> result.last)
    else $error("single result not marked last");

    // Only a finished packet carries a latency.
    a_latency_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STS_FINISHED) |-> (result.latency == '0))
    else $error("latency on a result other than finished");

    // A free slot flushes with a zero id.
    a_flush_free_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STS_FLUSH && !result.entry_valid)
            |-> (result.result_id == '0))
    else $error("free slot flushed with nonzero id");

endmodule

bind packet_latency_tracker_unit pltr_checker u_pltr_checker (.*);
